/* design/sac_pkg.sv */
// ---------------------------------------------------------------------------
// sac_pkg
// Shared types and constants for the swept box collision time pipeline.
// ---------------------------------------------------------------------------
package sac_pkg;

    localparam int POS_W  = 16;
    localparam int SIZE_W = 12;
    localparam int VEL_W  = 16;
    localparam int DIST_W = 18;   // entry/exit distance, signed pixels
    localparam int MAG_W  = 17;   // distance magnitude
    localparam int DEN_W  = 16;   // velocity magnitude, up to 32768
    localparam int QUO_W  = 17;   // unsaturated quotient bits
    localparam int TIME_W = 19;   // signed saturated time
    localparam int FRAC_SHIFT = 7; // 2^24 / 2^17: dividend bits above the quotient

    localparam int DIV_STEPS       = 17;
    localparam int STEPS_PER_STAGE = 3;
    localparam int DIV_STAGES      = (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    // operand stage + step stages + sign/saturate stage
    localparam int DIV_LAT         = DIV_STAGES + 2;

    typedef logic signed [DIST_W-1:0] dist_t;
    typedef logic signed [TIME_W-1:0] time_t;
    typedef logic signed [1:0]        norm_t;

    localparam time_t TIME_ONE = time_t'(65536);
    localparam time_t SAT_POS  = time_t'(131071);
    localparam time_t SAT_NEG  = time_t'(-131072);

    localparam norm_t NORM_POS  = 2'sb01;
    localparam norm_t NORM_NEG  = 2'sb11;
    localparam norm_t NORM_NONE = 2'sb00;

    typedef struct packed {
        time_t tval;
        logic  zero;   // velocity was zero, time is meaningless
    } div_res_t;

endpackage

/* design/sac_div.sv */
// ---------------------------------------------------------------------------
// sac_div
// Pipelined signed divide of distance * 2^24 by Q8.8 velocity, rounded
// toward zero, saturated to the signed time range.
// ---------------------------------------------------------------------------
module sac_div (
    input  logic                clk,
    input  logic                en,
    input  sac_pkg::dist_t      num,
    input  logic signed [15:0]  vel,
    output sac_pkg::div_res_t   res
);
    import sac_pkg::*;

    logic [DEN_W-1:0] den_reg  [DIV_STAGES+1];
    logic [DEN_W-1:0] rem_reg  [DIV_STAGES+1];
    logic [QUO_W-1:0] quo_reg  [DIV_STAGES+1];
    logic             neg_reg  [DIV_STAGES+1];
    logic             zero_reg [DIV_STAGES+1];
    logic             ovf_reg  [DIV_STAGES+1];
    div_res_t         res_reg;

    logic [MAG_W-1:0]            mag;
    logic [DEN_W-1:0]            den;
    logic                        ovf;
    logic [MAG_W+FRAC_SHIFT-1:0] rem_init;

    always_comb
    begin
        mag      = num[DIST_W-1] ? MAG_W'(-num) : MAG_W'(num);
        den      = vel[VEL_W-1] ? DEN_W'(-vel) : DEN_W'(vel);
        rem_init = {mag, FRAC_SHIFT'(0)};
        // quotient would need more than QUO_W bits
        ovf      = rem_init >= (MAG_W+FRAC_SHIFT)'(den);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0]  <= den;
            rem_reg[0]  <= ovf ? '0 : DEN_W'(rem_init);
            quo_reg[0]  <= '0;
            neg_reg[0]  <= num[DIST_W-1] ^ vel[VEL_W-1];
            zero_reg[0] <= (vel == '0);
            ovf_reg[0]  <= ovf;
        end
    end

    for (genvar s = 1; s <= DIV_STAGES; s++)
    begin : g_step
        logic [DEN_W-1:0] r;
        logic [QUO_W-1:0] q;
        logic [DEN_W:0]   r2;

        always_comb
        begin
            r  = rem_reg[s-1];
            q  = quo_reg[s-1];
            r2 = '0;
            for (int k = 0; k < STEPS_PER_STAGE; k++)
            begin
                if ((s - 1) * STEPS_PER_STAGE + k < DIV_STEPS)
                begin
                    r2 = {r, 1'b0};
                    q  = {q[QUO_W-2:0], 1'b0};
                    if (r2 >= {1'b0, den_reg[s-1]})
                    begin
                        r2   = r2 - {1'b0, den_reg[s-1]};
                        q[0] = 1'b1;
                    end
                    r = r2[DEN_W-1:0];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[s]  <= den_reg[s-1];
                rem_reg[s]  <= r;
                quo_reg[s]  <= q;
                neg_reg[s]  <= neg_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
                ovf_reg[s]  <= ovf_reg[s-1];
            end
        end
    end

    time_t qs;

    always_comb
    begin
        if (ovf_reg[DIV_STAGES])
            qs = neg_reg[DIV_STAGES] ? SAT_NEG : SAT_POS;
        else if (neg_reg[DIV_STAGES])
            qs = -time_t'(quo_reg[DIV_STAGES]);
        else
            qs = time_t'(quo_reg[DIV_STAGES]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.tval <= qs;
            res_reg.zero <= zero_reg[DIV_STAGES];
        end
    end

    assign res = res_reg;

endmodule

/* design/swept_aabb_collision_time_core.sv */
// Pipeline: entry stage, then the 17-step restoring divider (3 quotient bits per stage)
// with its operand and sign stages, then the decision stage.
// Throughput: one item per cycle; the whole pipeline holds while out_stall
// is high with a result waiting.
// Reset: rst_n clears all valid bits asynchronously; data registers are not reset.
// ---------------------------------------------------------------------------
// swept_aabb_collision_time_core
// Swept moving box against static box: entry time and struck face normal.
// ---------------------------------------------------------------------------
module swept_aabb_collision_time_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] mover_x,
    input  logic signed [15:0] mover_y,
    input  logic [11:0]        mover_w,
    input  logic [11:0]        mover_h,
    input  logic signed [15:0] vel_x,
    input  logic signed [15:0] vel_y,
    input  logic signed [15:0] target_x,
    input  logic signed [15:0] target_y,
    input  logic [11:0]        target_w,
    input  logic [11:0]        target_h,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic [16:0]        hit_time,
    output logic signed [1:0]  normal_x,
    output logic signed [1:0]  normal_y
);
    import sac_pkg::*;

    logic adv;
    logic out_valid_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // valid line: entry stage plus divider stages
    logic vld_reg [DIV_LAT+1];

    dist_t xen_d_reg, xex_d_reg, yen_d_reg, yex_d_reg;
    logic signed [VEL_W-1:0] vx_reg, vy_reg;
    logic xneg_reg [DIV_LAT+1];
    logic yneg_reg [DIV_LAT+1];

    dist_t mx_far, my_far, tx_far, ty_far;
    dist_t xen_d_next, xex_d_next, yen_d_next, yex_d_next;

    always_comb
    begin
        mx_far = dist_t'(mover_x) + dist_t'(mover_w);
        my_far = dist_t'(mover_y) + dist_t'(mover_h);
        tx_far = dist_t'(target_x) + dist_t'(target_w);
        ty_far = dist_t'(target_y) + dist_t'(target_h);
        if (vel_x > 0)
        begin
            xen_d_next = dist_t'(target_x) - mx_far;
            xex_d_next = tx_far - dist_t'(mover_x);
        end
        else
        begin
            xen_d_next = tx_far - dist_t'(mover_x);
            xex_d_next = dist_t'(target_x) - mx_far;
        end
        if (vel_y > 0)
        begin
            yen_d_next = dist_t'(target_y) - my_far;
            yex_d_next = ty_far - dist_t'(mover_y);
        end
        else
        begin
            yen_d_next = ty_far - dist_t'(mover_y);
            yex_d_next = dist_t'(target_y) - my_far;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i <= DIV_LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xen_d_reg   <= xen_d_next;
            xex_d_reg   <= xex_d_next;
            yen_d_reg   <= yen_d_next;
            yex_d_reg   <= yex_d_next;
            vx_reg      <= vel_x;
            vy_reg      <= vel_y;
            xneg_reg[0] <= xen_d_next[DIST_W-1];
            yneg_reg[0] <= yen_d_next[DIST_W-1];
            for (int i = 1; i <= DIV_LAT; i++)
            begin
                xneg_reg[i] <= xneg_reg[i-1];
                yneg_reg[i] <= yneg_reg[i-1];
            end
        end
    end

    div_res_t xen_res, xex_res, yen_res, yex_res;

    sac_div u_div_xen (.clk(clk), .en(adv), .num(xen_d_reg), .vel(vx_reg), .res(xen_res));
    sac_div u_div_xex (.clk(clk), .en(adv), .num(xex_d_reg), .vel(vx_reg), .res(xex_res));
    sac_div u_div_yen (.clk(clk), .en(adv), .num(yen_d_reg), .vel(vy_reg), .res(yen_res));
    sac_div u_div_yex (.clk(clk), .en(adv), .num(yex_d_reg), .vel(vy_reg), .res(yex_res));

    // zero velocity: entry at minus infinity, exit at plus infinity
    time_t xen_t, xex_t, yen_t, yex_t, entry_t, exit_t;
    logic  hit_next;
    logic  [16:0] time_next;
    norm_t nx_next, ny_next;

    always_comb
    begin
        xen_t   = xen_res.zero ? SAT_NEG : xen_res.tval;
        xex_t   = xex_res.zero ? SAT_POS : xex_res.tval;
        yen_t   = yen_res.zero ? SAT_NEG : yen_res.tval;
        yex_t   = yex_res.zero ? SAT_POS : yex_res.tval;
        entry_t = (xen_t > yen_t) ? xen_t : yen_t;
        exit_t  = (xex_t < yex_t) ? xex_t : yex_t;
        hit_next = !((entry_t > exit_t) || (xen_t < 0 && yen_t < 0) ||
                     (xen_t > TIME_ONE) || (yen_t > TIME_ONE));
        time_next = TIME_ONE[16:0];
        nx_next   = NORM_NONE;
        ny_next   = NORM_NONE;
        if (hit_next)
        begin
            time_next = entry_t[16:0];
            if (xen_t > yen_t)
                nx_next = xneg_reg[DIV_LAT] ? NORM_POS : NORM_NEG;
            else
                ny_next = yneg_reg[DIV_LAT] ? NORM_POS : NORM_NEG;
        end
    end

    logic        hit_reg;
    logic [16:0] time_reg;
    norm_t       nx_reg, ny_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= vld_reg[DIV_LAT];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg  <= hit_next;
            time_reg <= time_next;
            nx_reg   <= nx_next;
            ny_reg   <= ny_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign hit_time  = time_reg;
    assign normal_x  = nx_reg;
    assign normal_y  = ny_reg;

`ifndef SYNTH
    a_hit_one_face: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> ((normal_x == NORM_NONE) != (normal_y == NORM_NONE)))
        else $error("hit without exactly one face normal");

    a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> (hit_time == TIME_ONE[16:0] && normal_x == NORM_NONE &&
                               normal_y == NORM_NONE))
        else $error("miss result fields not cleared");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> ($stable(vld_reg[DIV_LAT]) && $stable(vld_reg[0])))
        else $error("pipeline moved while stalled");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> hit_time <= TIME_ONE[16:0])
        else $error("hit time beyond one frame");
`endif

endmodule

/* sim/swept_aabb_collision_time_core_tb.sv */
// ---------------------------------------------------------------------------
// swept_aabb_collision_time_core_tb
// Drives box pairs through the swept collision core under varied idling and
// a long output hold-off; checks results against typed verdicts or a predictor.
// ---------------------------------------------------------------------------
module swept_aabb_collision_time_core_tb;

    import sac_pkg::*;

    localparam int  N_RANDOM    = 1430;
    localparam int  LATENCY     = 10;
    localparam int  CYCLE_LIMIT = 400000;
    localparam longint T_ONE    = 65536;
    localparam longint T_INF    = longint'(1) << 62;

    typedef struct packed {
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic [11:0]        mw;
        logic [11:0]        mh;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic [11:0]        tw;
        logic [11:0]        th;
    } pair_t;

    typedef struct packed {
        logic        hit;
        logic [16:0] tm;
        norm_t       nx;
        norm_t       ny;
    } verdict_t;

    typedef struct packed {
        pair_t    p;
        logic     typed;   // expected verdict given in the row
        verdict_t v;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    pair_t drv = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic hit;
    logic [16:0] hit_time;
    logic signed [1:0] normal_x;
    logic signed [1:0] normal_y;

    verdict_t verdicts_due[$];
    int  mismatches = 0;
    int  cycles = 0;
    int  idle_pct = 0;
    int  stall_pct = 0;
    bit  hold_off = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    swept_aabb_collision_time_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mover_x(drv.mx), .mover_y(drv.my), .mover_w(drv.mw), .mover_h(drv.mh),
        .vel_x(drv.vx), .vel_y(drv.vy), .target_x(drv.tx), .target_y(drv.ty),
        .target_w(drv.tw), .target_h(drv.th),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .hit_time(hit_time), .normal_x(normal_x), .normal_y(normal_y)
    );

    // entry distance and Q16 entry/exit times for one axis
    function automatic void sweep(input longint pos, input longint sz, input longint vel,
                                  input longint tpos, input longint tsz,
                                  output longint d_in, output longint t_in,
                                  output longint t_out);
        longint d_out;
        begin
            if (vel > 0)
            begin
                d_in  = tpos - (pos + sz);
                d_out = (tpos + tsz) - pos;
            end
            else
            begin
                d_in  = (tpos + tsz) - pos;
                d_out = tpos - (pos + sz);
            end
            if (vel == 0)
            begin
                t_in  = -T_INF;
                t_out = T_INF;
            end
            else
            begin
                t_in  = (d_in * 16777216) / vel;   // truncates toward zero
                t_out = (d_out * 16777216) / vel;
            end
        end
    endfunction

    function automatic verdict_t collision_of(pair_t p);
        longint xd, xen, xex, yd, yen, yex, en, ex;
        verdict_t v;
        begin
            sweep(p.mx, p.mw, p.vx, p.tx, p.tw, xd, xen, xex);
            sweep(p.my, p.mh, p.vy, p.ty, p.th, yd, yen, yex);
            en = (xen > yen) ? xen : yen;
            ex = (xex < yex) ? xex : yex;
            v = '{hit: 1'b0, tm: 17'(T_ONE), nx: NORM_NONE, ny: NORM_NONE};
            if (!(en > ex || (xen < 0 && yen < 0) || xen > T_ONE || yen > T_ONE))
            begin
                v.hit = 1'b1;
                v.tm  = 17'(en);
                if (xen > yen)
                    v.nx = (xd < 0) ? NORM_POS : NORM_NEG;
                else
                    v.ny = (yd < 0) ? NORM_POS : NORM_NEG;
            end
            return v;
        end
    endfunction

    function automatic pair_t mk(int mx, int my, int mw, int mh, int vx, int vy,
                                 int tx, int ty, int tw, int th);
        return '{mx: 16'(mx), my: 16'(my), mw: 12'(mw), mh: 12'(mh), vx: 16'(vx),
                 vy: 16'(vy), tx: 16'(tx), ty: 16'(ty), tw: 12'(tw), th: 12'(th)};
    endfunction

    localparam verdict_t MISS = '{hit: 1'b0, tm: 17'd65536, nx: NORM_NONE, ny: NORM_NONE};

    function automatic row_t typed_row(pair_t p, verdict_t v);
        return '{p: p, typed: 1'b1, v: v};
    endfunction

    function automatic row_t open_row(pair_t p);
        return '{p: p, typed: 1'b0, v: '0};
    endfunction

    // mostly boxes in a small neighbourhood so hits are common; some wide noise
    function automatic pair_t random_pair();
        pair_t p;
        begin
            p = pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            if ($urandom_range(0, 9) < 7)
            begin
                p.mx = 16'($signed($urandom_range(0, 400)) - 200);
                p.my = 16'($signed($urandom_range(0, 400)) - 200);
                p.tx = p.mx + 16'($signed($urandom_range(0, 300)) - 150);
                p.ty = p.my + 16'($signed($urandom_range(0, 300)) - 150);
                p.mw = 12'($urandom_range(0, 60));
                p.mh = 12'($urandom_range(0, 60));
                p.tw = 12'($urandom_range(0, 60));
                p.th = 12'($urandom_range(0, 60));
                case ($urandom_range(0, 5))
                    0: p.vx = '0;
                    1: p.vy = '0;
                    2: begin p.vx = 16'($signed($urandom_range(0, 16000)) - 8000); end
                    default: begin end
                endcase
            end
            return p;
        end
    endfunction

    task automatic send(input pair_t p, input verdict_t v, input bit typed);
        begin
            while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            drv <= p;
            verdicts_due.push_back(typed ? v : collision_of(p));
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
        end
    endtask

    task automatic drain();
        begin
            in_valid <= 1'b0;
            while (verdicts_due.size() != 0)
                @(posedge clk);
        end
    endtask

    // receiver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (verdicts_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: hit=%0d time=%0d", hit, hit_time);
                end
                else
                begin
                    verdict_t e;
                    e = verdicts_due.pop_front();
                    if (e.hit !== hit || e.tm !== hit_time ||
                        e.nx !== normal_x || e.ny !== normal_y)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp hit=%0d t=%0d n=%0d,%0d",
                                      " got hit=%0d t=%0d n=%0d,%0d"},
                                     e.hit, e.tm, e.nx, e.ny, hit, hit_time, normal_x, normal_y);
                    end
                end
            end
            out_stall <= hold_off || (stall_pct != 0 && $urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    row_t rows[$];

    initial
    begin
        rows.push_back(typed_row(mk(0, 0, 10, 10, 0, 0, 100, 100, 10, 10), MISS));
        rows.push_back(typed_row(mk(0, 0, 10, 10, 0, 0, 5, 5, 10, 10), MISS));
        // 50 px gap, 100 px/frame in x: entry at half frame, left face struck
        rows.push_back(typed_row(mk(0, 0, 10, 10, 100 * 256, 0, 60, 0, 10, 10),
                       '{hit: 1'b1, tm: 17'd32768, nx: NORM_NEG, ny: NORM_NONE}));
        rows.push_back(typed_row(mk(60, 0, 10, 10, -100 * 256, 0, 0, 0, 10, 10),
                       '{hit: 1'b1, tm: 17'd32768, nx: NORM_POS, ny: NORM_NONE}));
        rows.push_back(typed_row(mk(0, 0, 10, 10, 0, 100 * 256, 0, 60, 10, 10),
                       '{hit: 1'b1, tm: 17'd32768, nx: NORM_NONE, ny: NORM_NEG}));
        rows.push_back(typed_row(mk(0, 0, 10, 10, 0, 10 * 256, 0, 500, 10, 10), MISS));
        rows.push_back(open_row(mk(0, 0, 10, 10, 100 * 256, 100 * 256, 60, 60, 10, 10)));
        rows.push_back(open_row(mk(0, 0, 10, 10, 50 * 256, 100 * 256, 30, 60, 10, 10)));
        rows.push_back(open_row(mk(0, 0, 10, 10, 50 * 256, 100 * 256, 30, 70, 10, 10)));
        rows.push_back(open_row(mk(0, 0, 10, 10, 10 * 256, 0, 20, 0, 10, 10)));
        rows.push_back(open_row(mk(0, 0, 10, 10, 1, -1, 10, -10, 0, 0)));
        rows.push_back(open_row(mk(-32768, -32768, 4095, 4095, 32767, 32767,
                                   32767, 32767, 4095, 4095)));
        rows.push_back(open_row(mk(32767, 32767, 4095, 4095, -32768, -32768,
                                   -32768, -32768, 4095, 4095)));
        rows.push_back(open_row(mk(32767, -32768, 0, 4095, -32768, 32767,
                                   -32768, 32767, 4095, 0)));
        rows.push_back(open_row(mk(-32768, 32767, 4095, 0, 32767, -32768,
                                   32767, -32768, 0, 4095)));
        rows.push_back(open_row(mk(0, 0, 4095, 4095, 1, 1, 0, 0, 4095, 4095)));
        rows.push_back(open_row(mk(0, 0, 10, 10, -1, -32768, 5, -4000, 10, 10)));
        rows.push_back(open_row(mk(0, 0, 0, 0, 256, 256, 1, 1, 0, 0)));
        rows.push_back(open_row(mk(100, 100, 10, 10, 300, -300, 0, 0, 200, 200)));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send(rows[i].p, rows[i].v, rows[i].typed);
        drain();

        // long output hold-off while the sender keeps offering items
        fork
            begin
                hold_off = 1'b1;
                repeat (60) @(posedge clk);
                hold_off = 1'b0;
            end
            repeat (40) send(random_pair(), '0, 1'b0);
        join
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 51; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 51; end
                3: begin idle_pct = 21; stall_pct = 21; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            repeat ((N_RANDOM - 40) / 5) send(random_pair(), '0, 1'b0);
        end
        drain();
        repeat (LATENCY * 3) @(posedge clk);

        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
